// ===== rtl/core/amre_pkg.sv =====
// shared constants and transfer types of the audio mix ring engine
package amre_pkg;

  // ring size in frames, a power of two
  localparam int RING_FRAMES  = 8192;
  localparam int STREAM_SLOTS = 64;

  localparam int ADDR_W   = $clog2(RING_FRAMES);
  localparam int SLOT_W   = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
  localparam int PTR_W    = 32;
  localparam int ACC_W    = 22;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 17;
  localparam int LEVEL_W  = 14;
  localparam int ID_W     = 6;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;

  // level saturates at the ring size and at the field limit
  localparam int LEVEL_MAX = (RING_FRAMES < 16383) ? RING_FRAMES : 16383;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(65536);

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RIGHT = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]           command;
    logic [ID_W-1:0]            stream_id;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic [LEVEL_W-1:0]         level;
  } result_t;

endpackage

// ===== rtl/core/audio_mix_ring_engine_core.sv =====
// stereo mixing ring engine: accumulator ring, loopback ring and stream pointers
//
// One command is taken when start is high and busy is low. A stop finishes in the
// pointer state, a write or a loopback read in the ring memory state and a drain
// in the multiply state; the sequencer walks one read-modify-write through the
// pointer memories and then the ring memories, each with a registered read, and
// a drain adds a state for the gain multiply. done pulses for one cycle with the
// result and cannot be held off, so the receiver must take it then. After reset the
// engine zeroes both rings, one frame a cycle, and stays busy until the last frame
// is cleared; gain writes are taken at any time on the cfg channel, which is always
// ready, and must only be issued while no command is in flight.
module audio_mix_ring_engine_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  amre_pkg::request_t                  request,
  output logic                                done,
  output amre_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [amre_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [amre_pkg::GAIN_W-1:0]         cfg_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PTR   = 3'd2;
  localparam logic [2:0] S_MEM   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;

  localparam int AW = amre_pkg::ADDR_W;
  localparam int PW = amre_pkg::PTR_W;
  localparam int CW = amre_pkg::ACC_W;
  localparam int SW = amre_pkg::SAMPLE_W;
  localparam int PROD_W = SW + amre_pkg::GAIN_W + 1;

  // saturating add of a sample into a 22-bit accumulator channel
  function automatic logic signed [CW-1:0] acc_add(input logic signed [CW-1:0] acc,
                                                   input logic signed [SW-1:0] s);
    logic signed [CW:0] sum;
    sum = {acc[CW-1], acc} + {{(CW+1-SW){s[SW-1]}}, s};
    if (sum[CW] != sum[CW-1]) begin
      acc_add = sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      acc_add = sum[CW-1:0];
    end
  endfunction

  // clip an accumulator channel to the sample range
  function automatic logic signed [SW-1:0] clip_sample(input logic signed [CW-1:0] acc);
    if (acc > 32767) begin
      clip_sample = 16'sh7fff;
    end else if (acc < -32768) begin
      clip_sample = 16'sh8000;
    end else begin
      clip_sample = acc[SW-1:0];
    end
  endfunction

  // divide a gain product by 65536, truncating toward zero
  function automatic logic signed [SW-1:0] unscale(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;
    biased  = p + (p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    shifted = biased >>> 16;
    unscale = shifted[SW-1:0];
  endfunction

  // distance to level, negative gives zero, large saturates
  function automatic logic [amre_pkg::LEVEL_W-1:0] level_of(input logic signed [PW-1:0] d);
    if (d < 0) begin
      level_of = '0;
    end else if (d > amre_pkg::LEVEL_MAX) begin
      level_of = amre_pkg::LEVEL_W'(amre_pkg::LEVEL_MAX);
    end else begin
      level_of = d[amre_pkg::LEVEL_W-1:0];
    end
  endfunction

  // memories
  logic [2*CW-1:0] acc_mem [amre_pkg::RING_FRAMES];
  logic [2*SW-1:0] lb_mem  [amre_pkg::RING_FRAMES];
  logic [PW-1:0]   wp_mem  [amre_pkg::STREAM_SLOTS];
  logic [PW-1:0]   rp_mem  [amre_pkg::STREAM_SLOTS];

  // control state
  logic [2:0]                        state;
  logic [AW-1:0]                     clr_cnt;
  logic [amre_pkg::STREAM_SLOTS-1:0] running;
  logic [PW-1:0]                     mix_ptr;
  logic [amre_pkg::GAIN_W-1:0]       gain_left;
  logic [amre_pkg::GAIN_W-1:0]       gain_right;

  // command held through the sequence
  logic [amre_pkg::CMD_W-1:0]        cmd_q;
  logic [amre_pkg::SLOT_W-1:0]       id_q;
  logic                              id_ok_q;
  logic                              run_q;
  logic signed [SW-1:0]              left_q;
  logic signed [SW-1:0]              right_q;
  logic [AW-1:0]                     slot_q;
  logic                              wr_ok_q;
  logic                              rd_ok_q;
  logic [amre_pkg::STATUS_W-1:0]     status_q;
  logic [amre_pkg::LEVEL_W-1:0]      level_q;
  logic signed [PROD_W-1:0]          prod_l;
  logic signed [PROD_W-1:0]          prod_r;

  // memory read data
  logic [PW-1:0]   wp_rd;
  logic [PW-1:0]   rp_rd;
  logic [2*CW-1:0] acc_rd;
  logic [2*SW-1:0] lb_rd;

  logic                        accept;
  logic [amre_pkg::SLOT_W-1:0] id_idx;

  assign accept    = start && (state == S_IDLE);
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign id_idx    = amre_pkg::SLOT_W'(request.stream_id);

  // pointer stage: effective pointers, distances and ring slot
  logic [PW-1:0]        wp_eff;
  logic [PW-1:0]        rp_eff;
  logic [PW-1:0]        rp_use;
  logic signed [PW-1:0] w_dist;
  logic signed [PW-1:0] w_dist1;
  logic signed [PW-1:0] r_dist;
  logic                 w_ok;
  logic                 r_empty;
  logic                 r_lag;
  logic [AW-1:0]        slot_c;

  always_comb begin
    wp_eff  = run_q ? wp_rd : mix_ptr;
    rp_eff  = run_q ? rp_rd : mix_ptr;
    w_dist  = signed'(wp_eff - mix_ptr);
    w_dist1 = signed'(wp_eff + PW'(1) - mix_ptr);
    r_dist  = signed'(mix_ptr - rp_eff);
    w_ok    = (w_dist < (amre_pkg::RING_FRAMES - 1));
    r_empty = (r_dist <= 0);
    r_lag   = (r_dist > amre_pkg::RING_FRAMES);
    rp_use  = r_lag ? (mix_ptr - PW'(amre_pkg::RING_FRAMES)) : rp_eff;
    unique case (cmd_q)
      amre_pkg::CMD_WRITE: slot_c = wp_eff[AW-1:0];
      amre_pkg::CMD_READ:  slot_c = rp_use[AW-1:0];
      default:             slot_c = mix_ptr[AW-1:0];
    endcase
  end

  // pointer memory writes
  logic          wp_we;
  logic          rp_we;
  logic [PW-1:0] rp_wdata;

  always_comb begin
    wp_we    = (state == S_PTR) && (cmd_q == amre_pkg::CMD_WRITE) && id_ok_q && w_ok;
    rp_we    = (state == S_PTR) && (cmd_q == amre_pkg::CMD_READ) && id_ok_q &&
               (!r_empty || !run_q);
    rp_wdata = r_empty ? rp_eff : (rp_use + PW'(1));
  end

  always_ff @(posedge clk) begin
    if (wp_we) begin
      wp_mem[id_q] <= wp_eff + PW'(1);
    end
    wp_rd <= wp_mem[id_idx];
  end

  always_ff @(posedge clk) begin
    if (rp_we) begin
      rp_mem[id_q] <= rp_wdata;
    end
    rp_rd <= rp_mem[id_idx];
  end

  // accumulator update, drain clear and clearing pass
  logic signed [CW-1:0] sum_l;
  logic signed [CW-1:0] sum_r;
  logic                 acc_we;
  logic [AW-1:0]        acc_waddr;
  logic [2*CW-1:0]      acc_wdata;

  always_comb begin
    sum_l     = acc_add(acc_rd[2*CW-1:CW], left_q);
    sum_r     = acc_add(acc_rd[CW-1:0], right_q);
    acc_we    = 1'b0;
    acc_waddr = slot_q;
    acc_wdata = '0;
    if (state == S_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_cnt;
    end else if (state == S_MEM && cmd_q == amre_pkg::CMD_WRITE && wr_ok_q) begin
      acc_we    = 1'b1;
      acc_wdata = {sum_l, sum_r};
    end else if (state == S_MEM && cmd_q == amre_pkg::CMD_DRAIN) begin
      acc_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rd <= acc_mem[slot_c];
  end

  // loopback ring: drained frames and clearing pass
  logic signed [SW-1:0] scaled_l;
  logic signed [SW-1:0] scaled_r;
  logic                 lb_we;
  logic [AW-1:0]        lb_waddr;
  logic [2*SW-1:0]      lb_wdata;

  always_comb begin
    scaled_l = unscale(prod_l);
    scaled_r = unscale(prod_r);
    lb_we    = 1'b0;
    lb_waddr = slot_q;
    lb_wdata = '0;
    if (state == S_CLEAR) begin
      lb_we    = 1'b1;
      lb_waddr = clr_cnt;
    end else if (state == S_MUL) begin
      lb_we    = 1'b1;
      lb_wdata = {scaled_l, scaled_r};
    end
  end

  always_ff @(posedge clk) begin
    if (lb_we) begin
      lb_mem[lb_waddr] <= lb_wdata;
    end
    lb_rd <= lb_mem[slot_c];
  end

  // gain clamp and drain multiply operands
  logic [amre_pkg::GAIN_W-1:0] gain_eff_l;
  logic [amre_pkg::GAIN_W-1:0] gain_eff_r;
  logic signed [SW-1:0]        clip_l;
  logic signed [SW-1:0]        clip_r;

  always_comb begin
    gain_eff_l = (gain_left > amre_pkg::GAIN_UNITY) ? amre_pkg::GAIN_UNITY : gain_left;
    gain_eff_r = (gain_right > amre_pkg::GAIN_UNITY) ? amre_pkg::GAIN_UNITY : gain_right;
    clip_l     = clip_sample(acc_rd[2*CW-1:CW]);
    clip_r     = clip_sample(acc_rd[CW-1:0]);
  end

  // sequencer, stream flags, mix pointer and gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      running    <= '0;
      mix_ptr    <= '0;
      gain_left  <= amre_pkg::GAIN_UNITY;
      gain_right <= amre_pkg::GAIN_UNITY;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          amre_pkg::REG_GAIN_LEFT:  gain_left  <= cfg_data;
          amre_pkg::REG_GAIN_RIGHT: gain_right <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(amre_pkg::RING_FRAMES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            state <= S_PTR;
          end
        end
        S_PTR: begin
          if (id_ok_q && (cmd_q == amre_pkg::CMD_WRITE || cmd_q == amre_pkg::CMD_READ)) begin
            running[id_q] <= 1'b1;
          end
          if (cmd_q == amre_pkg::CMD_STOP) begin
            if (id_ok_q) begin
              running[id_q] <= 1'b0;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_MEM;
          end
        end
        S_MEM: begin
          if (cmd_q == amre_pkg::CMD_DRAIN) begin
            state <= S_MUL;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          mix_ptr <= mix_ptr + PW'(1);
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // command payload, per-stage results and the result register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= request.command;
      id_q    <= id_idx;
      id_ok_q <= (32'(request.stream_id) < amre_pkg::STREAM_SLOTS);
      run_q   <= running[id_idx];
      left_q  <= request.left_in;
      right_q <= request.right_in;
    end
    if (state == S_PTR) begin
      slot_q  <= slot_c;
      wr_ok_q <= id_ok_q && w_ok;
      rd_ok_q <= id_ok_q && !r_empty;
      if (cmd_q == amre_pkg::CMD_WRITE) begin
        if (!id_ok_q) begin
          status_q <= amre_pkg::STAT_FULL;
          level_q  <= '0;
        end else if (w_ok) begin
          status_q <= amre_pkg::STAT_DONE;
          level_q  <= level_of(w_dist1);
        end else begin
          status_q <= amre_pkg::STAT_FULL;
          level_q  <= level_of(w_dist);
        end
      end else if (!id_ok_q || r_empty) begin
        status_q <= amre_pkg::STAT_EMPTY;
        level_q  <= '0;
      end else begin
        status_q <= amre_pkg::STAT_DONE;
        level_q  <= level_of(r_dist);
      end
      result <= '{status: amre_pkg::STAT_DONE, left_out: '0, right_out: '0, level: '0};
    end
    if (state == S_MEM) begin
      prod_l <= PROD_W'(clip_l) * PROD_W'(signed'({1'b0, gain_eff_l}));
      prod_r <= PROD_W'(clip_r) * PROD_W'(signed'({1'b0, gain_eff_r}));
      if (cmd_q == amre_pkg::CMD_READ && rd_ok_q) begin
        result <= '{status: status_q, left_out: lb_rd[2*SW-1:SW],
                    right_out: lb_rd[SW-1:0], level: level_q};
      end else begin
        result <= '{status: status_q, left_out: '0, right_out: '0, level: level_q};
      end
    end
    if (state == S_MUL) begin
      result <= '{status: amre_pkg::STAT_DONE, left_out: scaled_l,
                  right_out: scaled_r, level: '0};
    end
  end

endmodule

// ===== tb/sv/audio_mix_ring_engine_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the audio mix ring engine core
module audio_mix_ring_engine_core_tb;

  localparam int ACC_HI = 2 ** (amre_pkg::ACC_W - 1) - 1;
  localparam int ACC_LO = -(2 ** (amre_pkg::ACC_W - 1));

  typedef enum bit [1:0] {ROLE_IDLE, ROLE_WRITER, ROLE_READER} stream_role_t;

  typedef struct {
    amre_pkg::request_t req;
    bit                 typed;
    amre_pkg::result_t  res;
  } mix_row_t;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  amre_pkg::request_t             request;
  logic                           done;
  amre_pkg::result_t              result;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [amre_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [amre_pkg::GAIN_W-1:0]    cfg_data;

  audio_mix_ring_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mirror of the engine state
  int                          sum_l   [amre_pkg::RING_FRAMES];
  int                          sum_r   [amre_pkg::RING_FRAMES];
  shortint                     echo_l  [amre_pkg::RING_FRAMES];
  shortint                     echo_r  [amre_pkg::RING_FRAMES];
  logic [amre_pkg::PTR_W-1:0]  mix_ptr = '0;
  bit                          live    [amre_pkg::STREAM_SLOTS];
  logic [amre_pkg::PTR_W-1:0]  wr_ptr  [amre_pkg::STREAM_SLOTS];
  logic [amre_pkg::PTR_W-1:0]  rd_ptr  [amre_pkg::STREAM_SLOTS];
  logic [amre_pkg::GAIN_W-1:0] gain_l = amre_pkg::GAIN_UNITY;
  logic [amre_pkg::GAIN_W-1:0] gain_r = amre_pkg::GAIN_UNITY;

  // stimulus bookkeeping: which pointer each stream has started
  stream_role_t                role    [amre_pkg::STREAM_SLOTS];
  logic [amre_pkg::ID_W-1:0]   hot_ids [4];
  int                          drain_pct;
  bit                          idle_on;

  amre_pkg::result_t           mix_results_due [$];
  int                          mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("audio_mix_ring_engine_core_tb: done, errors");
    $finish;
  end

  function automatic longint ptr_dist(input logic [amre_pkg::PTR_W-1:0] a,
                                      input logic [amre_pkg::PTR_W-1:0] b);
    logic [amre_pkg::PTR_W-1:0] t;
    t = a - b;
    return longint'($signed(t));
  endfunction

  function automatic logic [amre_pkg::LEVEL_W-1:0] level_clamp(input longint d);
    if (d < 0) d = 0;
    if (d > amre_pkg::LEVEL_MAX) d = amre_pkg::LEVEL_MAX;
    return d[amre_pkg::LEVEL_W-1:0];
  endfunction

  function automatic int sat_acc(input int acc, input shortint s);
    int t;
    t = acc + s;
    if (t > ACC_HI) t = ACC_HI;
    if (t < ACC_LO) t = ACC_LO;
    return t;
  endfunction

  // clip to 16 bits, then scale by gain / 65536 truncating toward zero
  function automatic shortint gain_scale(input int acc, input logic [amre_pkg::GAIN_W-1:0] g);
    longint v;
    longint gg;
    v = acc;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    gg = (g > amre_pkg::GAIN_UNITY) ? longint'(amre_pkg::GAIN_UNITY) : longint'(g);
    return shortint'((v * gg) / longint'(amre_pkg::GAIN_UNITY));
  endfunction

  // one command against the mirrored state
  function automatic amre_pkg::result_t mix_ring_step(input amre_pkg::request_t req);
    amre_pkg::result_t           r;
    longint                      d;
    logic [amre_pkg::ADDR_W-1:0] slot;
    logic [amre_pkg::ID_W-1:0]   id;
    shortint                     lo;
    shortint                     ro;
    r = '0;
    r.status = amre_pkg::STAT_DONE;
    id = req.stream_id;
    case (req.command)
      amre_pkg::CMD_WRITE: begin
        if (!live[id]) begin
          wr_ptr[id] = mix_ptr;
          live[id] = 1'b1;
        end
        d = ptr_dist(wr_ptr[id], mix_ptr);
        if (d >= amre_pkg::RING_FRAMES - 1) begin
          r.status = amre_pkg::STAT_FULL;
        end else begin
          slot = wr_ptr[id][amre_pkg::ADDR_W-1:0];
          sum_l[slot] = sat_acc(sum_l[slot], req.left_in);
          sum_r[slot] = sat_acc(sum_r[slot], req.right_in);
          wr_ptr[id] = wr_ptr[id] + 1;
          d = ptr_dist(wr_ptr[id], mix_ptr);
        end
        r.level = level_clamp(d);
      end
      amre_pkg::CMD_DRAIN: begin
        slot = mix_ptr[amre_pkg::ADDR_W-1:0];
        lo = gain_scale(sum_l[slot], gain_l);
        ro = gain_scale(sum_r[slot], gain_r);
        echo_l[slot] = lo;
        echo_r[slot] = ro;
        sum_l[slot] = 0;
        sum_r[slot] = 0;
        mix_ptr = mix_ptr + 1;
        r.left_out = lo;
        r.right_out = ro;
      end
      amre_pkg::CMD_READ: begin
        if (!live[id]) begin
          rd_ptr[id] = mix_ptr;
          live[id] = 1'b1;
        end
        d = ptr_dist(mix_ptr, rd_ptr[id]);
        if (d <= 0) begin
          r.status = amre_pkg::STAT_EMPTY;
        end else begin
          // a reader lagging more than a ring jumps forward
          if (d > amre_pkg::RING_FRAMES) begin
            d = amre_pkg::RING_FRAMES;
            rd_ptr[id] = mix_ptr - amre_pkg::RING_FRAMES;
          end
          slot = rd_ptr[id][amre_pkg::ADDR_W-1:0];
          r.left_out = echo_l[slot];
          r.right_out = echo_r[slot];
          rd_ptr[id] = rd_ptr[id] + 1;
          r.level = level_clamp(d);
        end
      end
      default: begin
        live[id] = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic amre_pkg::request_t mk_req(input logic [amre_pkg::CMD_W-1:0] cmd,
                                                input logic [amre_pkg::ID_W-1:0] id,
                                                input logic [amre_pkg::SAMPLE_W-1:0] l,
                                                input logic [amre_pkg::SAMPLE_W-1:0] r);
    amre_pkg::request_t q;
    q.command = cmd;
    q.stream_id = id;
    q.left_in = l;
    q.right_in = r;
    return q;
  endfunction

  function automatic amre_pkg::result_t mk_res(input logic [amre_pkg::STATUS_W-1:0] st,
                                               input shortint l, input shortint r,
                                               input int lvl);
    amre_pkg::result_t q;
    q.status = st;
    q.left_out = l;
    q.right_out = r;
    q.level = lvl[amre_pkg::LEVEL_W-1:0];
    return q;
  endfunction

  function automatic logic [amre_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return amre_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // mostly well-formed traffic on a few hot streams, with some noise on any stream
  function automatic amre_pkg::request_t pick_item();
    amre_pkg::request_t q;
    int                 roll;
    if ($urandom_range(0, 9) == 0)
      q.stream_id = amre_pkg::ID_W'($urandom_range(0, amre_pkg::STREAM_SLOTS - 1));
    else q.stream_id = hot_ids[$urandom_range(0, 3)];
    q.left_in = pick_sample();
    q.right_in = pick_sample();
    roll = $urandom_range(0, 99);
    if (roll < drain_pct) begin
      q.command = amre_pkg::CMD_DRAIN;
    end else if (roll < drain_pct + 4) begin
      q.command = amre_pkg::CMD_STOP;
    end else begin
      case (role[q.stream_id])
        ROLE_WRITER: q.command = amre_pkg::CMD_WRITE;
        ROLE_READER: q.command = amre_pkg::CMD_READ;
        default: q.command = ($urandom_range(0, 1) == 0) ? amre_pkg::CMD_WRITE :
                                                            amre_pkg::CMD_READ;
      endcase
    end
    return q;
  endfunction

  // one command transfer; returns at the next falling edge with start still high
  task automatic send_cmd(input amre_pkg::request_t req, input bit typed,
                          input amre_pkg::result_t typed_res);
    amre_pkg::result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    start = 1'b1;
    request = req;
    do @(posedge clk); while (busy);
    predicted = mix_ring_step(req);
    mix_results_due.push_back(typed ? typed_res : predicted);
    case (req.command)
      amre_pkg::CMD_WRITE:
        if (role[req.stream_id] == ROLE_IDLE) role[req.stream_id] = ROLE_WRITER;
      amre_pkg::CMD_READ:
        if (role[req.stream_id] == ROLE_IDLE) role[req.stream_id] = ROLE_READER;
      amre_pkg::CMD_STOP: role[req.stream_id] = ROLE_IDLE;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // hold off until every outstanding result is back and the engine is idle
  task automatic wait_quiet();
    start = 1'b0;
    while (mix_results_due.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_gain(input logic [amre_pkg::CFG_IDX_W-1:0] idx,
                            input logic [amre_pkg::GAIN_W-1:0] val);
    start = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == amre_pkg::REG_GAIN_LEFT) gain_l = val;
    else gain_r = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    amre_pkg::result_t want;
    if (!rst && done) begin
      if (mix_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result: status %0d left %0d right %0d level %0d",
                   $realtime, result.status, result.left_out, result.right_out, result.level);
      end else begin
        want = mix_results_due.pop_front();
        if (result.status !== want.status || result.left_out !== want.left_out ||
            result.right_out !== want.right_out || result.level !== want.level) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: status %0d/%0d left %0d/%0d right %0d/%0d level %0d/%0d",
                     $realtime, want.status, result.status, want.left_out, result.left_out,
                     want.right_out, result.right_out, want.level, result.level);
        end
      end
    end
  end

  initial begin
    mix_row_t                    plan [$];
    logic [amre_pkg::GAIN_W-1:0] gl;
    logic [amre_pkg::GAIN_W-1:0] gr;
    logic [amre_pkg::ID_W-1:0]   fill_id;
    logic [amre_pkg::ID_W-1:0]   tap_id;
    logic [amre_pkg::ID_W-1:0]   sat_id;
    int                          wait_cycles;

    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    drain_pct = 20;
    foreach (role[i]) role[i] = ROLE_IDLE;
    foreach (hot_ids[i]) hot_ids[i] = '0;

    // directed rows: reader on an empty ring, clipping of a summed frame,
    // ignored fields on drain and stop, restart after stop, a writer behind the mix
    plan.push_back('{mk_req(amre_pkg::CMD_READ, 6'd5, 16'h0000, 16'h0000), 1'b1,
                     mk_res(amre_pkg::STAT_EMPTY, 0, 0, 0)});
    plan.push_back('{mk_req(amre_pkg::CMD_DRAIN, 6'd63, 16'h7fff, 16'h8000), 1'b1,
                     mk_res(amre_pkg::STAT_DONE, 0, 0, 0)});
    plan.push_back('{mk_req(amre_pkg::CMD_WRITE, 6'd0, 16'h7fff, 16'h8000), 1'b1,
                     mk_res(amre_pkg::STAT_DONE, 0, 0, 1)});
    plan.push_back('{mk_req(amre_pkg::CMD_WRITE, 6'd1, 16'h7fff, 16'h8000), 1'b1,
                     mk_res(amre_pkg::STAT_DONE, 0, 0, 1)});
    plan.push_back('{mk_req(amre_pkg::CMD_DRAIN, 6'd0, 16'h0000, 16'h0000), 1'b1,
                     mk_res(amre_pkg::STAT_DONE, 32767, -32768, 0)});
    plan.push_back('{mk_req(amre_pkg::CMD_READ, 6'd5, 16'hffff, 16'hffff), 1'b1,
                     mk_res(amre_pkg::STAT_DONE, 0, 0, 2)});
    plan.push_back('{mk_req(amre_pkg::CMD_READ, 6'd5, 16'h0000, 16'h0000), 1'b1,
                     mk_res(amre_pkg::STAT_DONE, 32767, -32768, 1)});
    plan.push_back('{mk_req(amre_pkg::CMD_READ, 6'd5, 16'h0000, 16'h0000), 1'b1,
                     mk_res(amre_pkg::STAT_EMPTY, 0, 0, 0)});
    plan.push_back('{mk_req(amre_pkg::CMD_STOP, 6'd0, 16'hffff, 16'h8000), 1'b1,
                     mk_res(amre_pkg::STAT_DONE, 0, 0, 0)});
    plan.push_back('{mk_req(amre_pkg::CMD_STOP, 6'd63, 16'h7fff, 16'hffff), 1'b1,
                     mk_res(amre_pkg::STAT_DONE, 0, 0, 0)});
    plan.push_back('{mk_req(amre_pkg::CMD_WRITE, 6'd63, 16'hffff, 16'h0001), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_WRITE, 6'd0, 16'h8000, 16'h7fff), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_WRITE, 6'd42, 16'h5555, 16'haaaa), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_WRITE, 6'd21, 16'haaaa, 16'h5555), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_WRITE, 6'd0, 16'h0001, 16'hfffe), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_DRAIN, 6'd42, 16'h1234, 16'h4321), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_DRAIN, 6'd21, 16'h0000, 16'h0000), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_WRITE, 6'd1, 16'h7fff, 16'h7fff), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_READ, 6'd5, 16'h0000, 16'h0000), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_STOP, 6'd5, 16'h0000, 16'h0000), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_READ, 6'd5, 16'h0000, 16'h0000), 1'b0, '0});
    plan.push_back('{mk_req(amre_pkg::CMD_DRAIN, 6'd0, 16'h0000, 16'h0000), 1'b0, '0});

    repeat (11) @(negedge clk);
    rst = 1'b0;

    // gains at unity for the directed rows
    write_gain(amre_pkg::REG_GAIN_LEFT, amre_pkg::GAIN_UNITY);
    write_gain(amre_pkg::REG_GAIN_RIGHT, amre_pkg::GAIN_UNITY);
    foreach (plan[i]) send_cmd(plan[i].req, plan[i].typed, plan[i].res);

    // random phases, each with its own gains, hot streams and drain rate
    for (int phase = 0; phase < 5; phase++) begin
      wait_quiet();
      case (phase)
        0: begin gl = '0; gr = '0; end
        1: begin gl = '1; gr = '1; end
        2: begin gl = 17'd1; gr = 17'd65535; end
        3: begin gl = amre_pkg::GAIN_UNITY; gr = amre_pkg::GAIN_UNITY; end
        default: begin
          gl = amre_pkg::GAIN_W'($urandom_range(0, 131071));
          gr = amre_pkg::GAIN_W'($urandom_range(0, 131071));
        end
      endcase
      write_gain(amre_pkg::REG_GAIN_LEFT, gl);
      write_gain(amre_pkg::REG_GAIN_RIGHT, gr);
      foreach (hot_ids[i])
        hot_ids[i] = amre_pkg::ID_W'($urandom_range(0, amre_pkg::STREAM_SLOTS - 1));
      drain_pct = $urandom_range(8, 30);
      for (int i = 0; i < 190; i++) begin
        if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 149) == 0) wait_quiet();
        // accumulator saturation: restart one stream on the same slot many times
        if (phase == 3 && i == 100) begin
          sat_id = amre_pkg::ID_W'($urandom_range(0, amre_pkg::STREAM_SLOTS - 1));
          for (int k = 0; k < 132; k++) begin
            send_cmd(mk_req(amre_pkg::CMD_STOP, sat_id, 16'h0000, 16'h0000), 1'b0, '0);
            if (k < 66)
              send_cmd(mk_req(amre_pkg::CMD_WRITE, sat_id, 16'h7fff, 16'h8000), 1'b0, '0);
            else
              send_cmd(mk_req(amre_pkg::CMD_WRITE, sat_id, 16'h8000, 16'h7fff), 1'b0, '0);
          end
          send_cmd(mk_req(amre_pkg::CMD_DRAIN, sat_id, 16'h0000, 16'h0000), 1'b0, '0);
        end
        send_cmd(pick_item(), 1'b0, '0);
      end
    end

    // back to back: a writer runs ahead, the mix drains past it, then a reader reads four of the drained frames
    wait_quiet();
    idle_on = 1'b0;
    fill_id = amre_pkg::ID_W'($urandom_range(0, 31));
    tap_id = fill_id + 6'd32;
    send_cmd(mk_req(amre_pkg::CMD_STOP, fill_id, 16'h0000, 16'h0000), 1'b0, '0);
    send_cmd(mk_req(amre_pkg::CMD_STOP, tap_id, 16'h0000, 16'h0000), 1'b0, '0);
    send_cmd(mk_req(amre_pkg::CMD_READ, tap_id, 16'h0000, 16'h0000), 1'b0, '0);
    repeat (40)
      send_cmd(mk_req(amre_pkg::CMD_WRITE, fill_id, pick_sample(), pick_sample()), 1'b0, '0);
    repeat (44)
      send_cmd(mk_req(amre_pkg::CMD_DRAIN, fill_id, 16'h0000, 16'h0000), 1'b0, '0);
    repeat (4) send_cmd(mk_req(amre_pkg::CMD_READ, tap_id, 16'h0000, 16'h0000), 1'b0, '0);
    repeat (2)
      send_cmd(mk_req(amre_pkg::CMD_WRITE, fill_id, pick_sample(), pick_sample()), 1'b0, '0);

    // let the last results come back
    start = 1'b0;
    wait_cycles = 0;
    while (mix_results_due.size() != 0 && wait_cycles < 2000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (16) @(negedge clk);
    if (mix_results_due.size() != 0) begin
      mismatches += mix_results_due.size();
      $display("%0t: %0d expected results never arrived", $realtime, mix_results_due.size());
    end

    if (mismatches == 0) begin
      $display("audio_mix_ring_engine_core_tb: done, clean");
    end else begin
      $display("audio_mix_ring_engine_core_tb: done, errors");
    end
    $finish;
  end

endmodule
